// File: hdl/thv_pkg.sv
// Package for the tar header validator: field positions, magic strings,
// format codes and the result record. No dependencies.
package thv_pkg;

    // Byte position inside a 512-byte header block
    typedef logic [8:0] pos_t;

    localparam pos_t NAME_END     = 9'd100;   // name field is bytes 0..99
    localparam pos_t MODE_END     = 9'd108;   // mode field is bytes 100..107
    localparam pos_t MTIME_FIRST  = 9'd136;   // mtime field is bytes 136..147
    localparam pos_t CK_FIRST     = 9'd148;   // checksum field is bytes 148..155
    localparam pos_t CK_LAST      = 9'd155;
    localparam pos_t MAGIC_AT     = 9'd257;
    localparam pos_t POSIX_LAST   = 9'd262;   // "ustar" NUL
    localparam pos_t GNU_LAST     = 9'd264;   // "ustar" space space NUL
    localparam pos_t BLOCK_LAST   = 9'd511;

    localparam logic [16:0] SUM_BASE = 17'd256;

    // Header format codes
    typedef enum logic [1:0] {
        FMT_V7    = 2'd0,
        FMT_GNU   = 2'd1,
        FMT_POSIX = 2'd2
    } hdr_fmt_t;

    // Result record carried from the scanner to the output register
    typedef struct packed {
        logic        is_header;
        hdr_fmt_t    header_format;
        logic [16:0] computed_sum;
        logic [23:0] stored_sum;
    } result_t;

    // Expected byte of the POSIX magic at an offset from MAGIC_AT
    function automatic logic [7:0] posix_magic_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h75;  // u
            3'd1:    ch = 8'h73;  // s
            3'd2:    ch = 8'h74;  // t
            3'd3:    ch = 8'h61;  // a
            3'd4:    ch = 8'h72;  // r
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Expected byte of the old GNU magic at an offset from MAGIC_AT
    function automatic logic [7:0] gnu_magic_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h75;
            3'd1:    ch = 8'h73;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h20;
            3'd6:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/tar_header_validator.sv
// Top level of the tar header validator: input register, scanner and
// result register. Depends on thv_pkg and thv_scan.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_       | s_valid / s_ready  | s_data_byte, s_last_byte
//  m_       | m_valid / m_ready  | m_is_header, m_header_format,
//           |                    | m_computed_sum, m_stored_sum
//
// One byte per cycle is taken unless a closing byte waits on a full result
// register. The scan reads the input register and loads the result register.
// Reset is synchronous, active low, and empties both registers and the scan.
// A stalled result holds only the byte that would close the next block;
// other bytes keep flowing through the scanner.
module tar_header_validator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_header,
    output logic [1:0]  m_header_format,
    output logic [16:0] m_computed_sum,
    output logic [23:0] m_stored_sum
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             out_valid_reg;
    thv_pkg::result_t out_reg;

    logic             result_req;
    thv_pkg::result_t result;
    logic             out_free;
    logic             advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!result_req || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    thv_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_in    (in_byte_reg),
        .last_in    (in_last_reg),
        .advance    (advance),
        .result_req (result_req),
        .result     (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && result_req;
        end
        if (advance && result_req) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_is_header     = out_reg.is_header;
    assign m_header_format = out_reg.header_format;
    assign m_computed_sum  = out_reg.computed_sum;
    assign m_stored_sum    = out_reg.stored_sum;

`ifndef SYNTHESIS
    // a held input byte means the scan is blocked by a full result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !s_ready) |-> (result_req && out_valid_reg && !m_ready))
        else $error("input held without a blocked result");

    // a passed header always carries matching sums
    a_pass_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_header) |-> ({7'd0, m_computed_sum} == m_stored_sum))
        else $error("header passed with differing sums");

    // format code stays within its three values
    a_fmt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_header_format != 2'd3))
        else $error("bad header format code");

    // a request is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_computed_sum)
            && $stable(m_stored_sum)))
        else $error("pending result overwritten");
`endif

endmodule

// File: hdl/thv_scan.sv
// Per-block scanner: position, running checksum, octal parse, field checks
// and magic match. Depends on thv_pkg.
module thv_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        byte_in,
    input  logic              last_in,
    input  logic              advance,      // take byte_in this cycle
    output logic              result_req,   // this byte closes the block
    output thv_pkg::result_t  result
);

    thv_pkg::pos_t pos_reg, pos_next;
    logic [16:0]   sum_reg, sum_next;
    logic [23:0]   oct_reg, oct_next;
    logic          oct_active_reg, oct_active_next;
    logic          name_done_reg, name_done_next;
    logic          mtime_done_reg, mtime_done_next;
    logic          fields_ok_reg, fields_ok_next;
    logic [1:0]    magic_reg, magic_next;

    logic          below_space;
    logic          is_octal;
    logic          full;
    thv_pkg::pos_t magic_off;

    assign below_space = (byte_in < 8'h20) || byte_in[7];
    assign is_octal    = (byte_in >= 8'h30) && (byte_in <= 8'h37);
    assign full        = (pos_reg == thv_pkg::BLOCK_LAST);
    assign magic_off   = pos_reg - thv_pkg::MAGIC_AT;
    assign result_req  = full || last_in;

    // State update for one byte
    always_comb begin
        name_done_next  = name_done_reg;
        mtime_done_next = mtime_done_reg;
        fields_ok_next  = fields_ok_reg;
        oct_next        = oct_reg;
        oct_active_next = oct_active_reg;
        sum_next        = sum_reg;
        magic_next      = magic_reg;

        // field character checks
        if (pos_reg < thv_pkg::NAME_END) begin
            if (!name_done_reg) begin
                if (byte_in == 8'h00) begin
                    name_done_next = 1'b1;
                end else if (below_space) begin
                    fields_ok_next = 1'b0;
                end
            end
        end else if (pos_reg < thv_pkg::MODE_END) begin
            if (!(byte_in == 8'h00 || byte_in == 8'h20 || is_octal)) begin
                fields_ok_next = 1'b0;
            end
        end else if (pos_reg >= thv_pkg::MTIME_FIRST && pos_reg < thv_pkg::CK_FIRST) begin
            if (!mtime_done_reg) begin
                if (byte_in == 8'h00) begin
                    mtime_done_next = 1'b1;
                end else if (below_space) begin
                    fields_ok_next = 1'b0;
                end
            end
        end

        // checksum field is parsed as octal, everything else is summed
        if (pos_reg >= thv_pkg::CK_FIRST && pos_reg <= thv_pkg::CK_LAST) begin
            if (oct_active_reg) begin
                if (is_octal) begin
                    oct_next = {oct_reg[20:0], byte_in[2:0]};
                end else begin
                    oct_active_next = 1'b0;
                end
            end
        end else begin
            sum_next = sum_reg + {9'd0, byte_in};
        end

        // magic string match
        if (pos_reg >= thv_pkg::MAGIC_AT && pos_reg <= thv_pkg::POSIX_LAST
                && thv_pkg::posix_magic_char(magic_off[2:0]) != byte_in) begin
            magic_next[0] = 1'b0;
        end
        if (pos_reg >= thv_pkg::MAGIC_AT && pos_reg <= thv_pkg::GNU_LAST
                && thv_pkg::gnu_magic_char(magic_off[2:0]) != byte_in) begin
            magic_next[1] = 1'b0;
        end

        pos_next = pos_reg + 9'd1;
    end

    // Result fields; an early end reports a failed V7 header
    always_comb begin
        result.computed_sum = sum_next;
        result.stored_sum   = oct_next;
        if (full) begin
            result.is_header = fields_ok_next && ({7'd0, sum_next} == oct_next);
            if (magic_next[0]) begin
                result.header_format = thv_pkg::FMT_POSIX;
            end else if (magic_next[1]) begin
                result.header_format = thv_pkg::FMT_GNU;
            end else begin
                result.header_format = thv_pkg::FMT_V7;
            end
        end else begin
            result.is_header     = 1'b0;
            result.header_format = thv_pkg::FMT_V7;
        end
    end

    // State registers; a closed block returns to the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && result_req)) begin
            pos_reg        <= '0;
            sum_reg        <= thv_pkg::SUM_BASE;
            oct_reg        <= '0;
            oct_active_reg <= 1'b1;
            name_done_reg  <= 1'b0;
            mtime_done_reg <= 1'b0;
            fields_ok_reg  <= 1'b1;
            magic_reg      <= 2'b11;
        end else if (advance) begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            oct_reg        <= oct_next;
            oct_active_reg <= oct_active_next;
            name_done_reg  <= name_done_next;
            mtime_done_reg <= mtime_done_next;
            fields_ok_reg  <= fields_ok_next;
            magic_reg      <= magic_next;
        end
    end

endmodule

// File: sim/tb_top.sv
// Self-checking bench for tar_header_validator: header blocks built in the bench,
// a byte-wise scan predictor and a result checker with random idling both sides.
// Depends on thv_pkg and the tar_header_validator RTL.
`timescale 1ns / 1ps

module tb_top;

    // Magic strings as packed bytes, first character in the top byte
    localparam logic [47:0] POSIX_TAG = {"ustar", 8'h00};
    localparam logic [63:0] GNU_TAG   = {"ustar  ", 8'h00};

    localparam int HOLD_CYCLES = 300;

    typedef enum int {MAGIC_POSIX, MAGIC_GNU, MAGIC_NONE, MAGIC_NEAR} magic_pick_t;
    typedef enum int {SUMFMT_SIX, SUMFMT_SEVEN, SUMFMT_EIGHT, SUMFMT_LEAD_SP,
                      SUMFMT_SEVENS} sum_style_t;
    typedef enum int {DMG_NONE, DMG_ANY, DMG_NAME, DMG_MODE, DMG_MTIME} damage_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_is_header;
    logic [1:0]  m_header_format;
    logic [16:0] m_computed_sum;
    logic [23:0] m_stored_sum;

    byte_req_t          byte_feed[$];
    thv_pkg::result_t   expected_verdicts[$];
    thv_pkg::result_t   due_verdict;
    logic [7:0]         hdr_img [0:511];

    int error_count = 0;
    int bytes_queued = 0;
    int blocks_queued = 0;
    int bytes_accepted = 0;
    int burst_from = 0;
    int quiet_from = 0;
    int quiet_to = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit byte_taken = 1'b0;

    // Predictor state for the block being scanned
    int          scan_pos;
    logic [16:0] sum_acc;
    logic [23:0] oct_acc;
    logic        octal_live;
    logic        name_nul_seen;
    logic        mtime_nul_seen;
    logic        fields_pass;
    logic [1:0]  magic_live;

    tar_header_validator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_header     (m_is_header),
        .m_header_format (m_header_format),
        .m_computed_sum  (m_computed_sum),
        .m_stored_sum    (m_stored_sum)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit is_ctrl(input logic [7:0] b);
        return b < 8'h20 || b >= 8'h80;   // signed byte below space
    endfunction

    function automatic bit is_octal(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h37;
    endfunction

    function automatic bit quiet_window();
        return bytes_accepted >= quiet_from && bytes_accepted < quiet_to;
    endfunction

    task automatic clear_scan();
        scan_pos       = 0;
        sum_acc        = thv_pkg::SUM_BASE;
        oct_acc        = '0;
        octal_live     = 1'b1;
        name_nul_seen  = 1'b0;
        mtime_nul_seen = 1'b0;
        fields_pass    = 1'b1;
        magic_live     = 2'b11;
    endtask

    // Advance the scan by one byte; queue a verdict when the block closes
    task automatic predict_header_scan(input logic [7:0] b, input logic last);
        thv_pkg::result_t v;
        bit               full;
        if (scan_pos < thv_pkg::NAME_END) begin
            if (!name_nul_seen) begin
                if (b == 8'h00) name_nul_seen = 1'b1;
                else if (is_ctrl(b)) fields_pass = 1'b0;
            end
        end else if (scan_pos < thv_pkg::MODE_END) begin
            if (!(b == 8'h00 || b == 8'h20 || is_octal(b))) fields_pass = 1'b0;
        end else if (scan_pos >= thv_pkg::MTIME_FIRST && scan_pos < thv_pkg::CK_FIRST) begin
            if (!mtime_nul_seen) begin
                if (b == 8'h00) mtime_nul_seen = 1'b1;
                else if (is_ctrl(b)) fields_pass = 1'b0;
            end
        end

        // Checksum field is parsed, everything else summed
        if (scan_pos >= thv_pkg::CK_FIRST && scan_pos <= thv_pkg::CK_LAST) begin
            if (octal_live) begin
                if (is_octal(b)) oct_acc = {oct_acc[20:0], b[2:0]};
                else octal_live = 1'b0;
            end
        end else begin
            sum_acc = sum_acc + 17'(b);
        end

        if (scan_pos >= thv_pkg::MAGIC_AT && scan_pos <= thv_pkg::POSIX_LAST &&
            POSIX_TAG[47 - 8*(scan_pos - thv_pkg::MAGIC_AT) -: 8] != b)
            magic_live[0] = 1'b0;
        if (scan_pos >= thv_pkg::MAGIC_AT && scan_pos <= thv_pkg::GNU_LAST &&
            GNU_TAG[63 - 8*(scan_pos - thv_pkg::MAGIC_AT) -: 8] != b)
            magic_live[1] = 1'b0;

        full = (scan_pos == thv_pkg::BLOCK_LAST);
        if (!full && !last) begin
            scan_pos++;
        end else begin
            if (full) begin
                v.is_header     = fields_pass && (24'(sum_acc) == oct_acc);
                v.header_format = magic_live[0] ? thv_pkg::FMT_POSIX :
                                  (magic_live[1] ? thv_pkg::FMT_GNU : thv_pkg::FMT_V7);
            end else begin
                v.is_header     = 1'b0;
                v.header_format = thv_pkg::FMT_V7;
            end
            v.computed_sum = sum_acc;
            v.stored_sum   = oct_acc;
            expected_verdicts.push_back(v);
            clear_scan();
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        byte_req_t req;
        req.data = b;
        req.last = last;
        byte_feed.push_back(req);
        bytes_queued++;
        if (last) blocks_queued++;
    endtask

    task automatic write_octal(input int at, input int digits, input int value);
        for (int i = 0; i < digits; i++)
            hdr_img[at + i] = 8'h30 + 8'((value >> (3 * (digits - 1 - i))) & 7);
    endtask

    // Build one header image and queue its first keep bytes
    task automatic queue_block(input magic_pick_t magic, input sum_style_t style,
                               input damage_t damage, input int keep, input bit end_flag);
        int          nlen;
        int          mlen;
        int          spot;
        int          span;
        int          sum;
        logic [63:0] tag;
        for (int i = 0; i < 512; i++) hdr_img[i] = 8'($urandom_range(0, 255));

        // printable name and mtime up to a NUL, legal mode characters
        nlen = $urandom_range(0, 100);
        for (int i = 0; i < nlen; i++) hdr_img[i] = 8'($urandom_range(32, 127));
        if (nlen < 100) hdr_img[nlen] = 8'h00;
        for (int i = 100; i < 108; i++) begin
            spot = $urandom_range(0, 9);
            hdr_img[i] = (spot == 0) ? 8'h00 : ((spot == 1) ? 8'h20 : 8'(8'h2e + spot));
        end
        mlen = $urandom_range(0, 12);
        for (int i = 0; i < mlen; i++) hdr_img[136 + i] = 8'($urandom_range(32, 127));
        if (mlen < 12) hdr_img[136 + mlen] = 8'h00;

        // magic string
        span = 0;
        tag  = '0;
        if (magic == MAGIC_POSIX || (magic == MAGIC_NEAR && $urandom_range(0, 1))) begin
            tag  = {POSIX_TAG, 16'h0000};
            span = 6;
        end else if (magic != MAGIC_NONE) begin
            tag  = GNU_TAG;
            span = 8;
        end
        for (int i = 0; i < span; i++) hdr_img[257 + i] = tag[63 - 8*i -: 8];
        if (magic == MAGIC_NEAR) begin
            spot = $urandom_range(0, span - 1);
            hdr_img[257 + spot] = hdr_img[257 + spot] ^ 8'($urandom_range(1, 255));
        end

        // targeted field damage, checksum still made to agree
        case (damage)
            DMG_NAME: begin
                spot = $urandom_range(0, 99);
                hdr_img[spot] = $urandom_range(0, 1) ? 8'($urandom_range(1, 31)) :
                                                       8'($urandom_range(128, 255));
            end
            DMG_MODE:  hdr_img[$urandom_range(100, 107)] = 8'($urandom_range(0, 255));
            DMG_MTIME: hdr_img[$urandom_range(136, 147)] = 8'($urandom_range(128, 255));
            default: ;
        endcase

        sum = thv_pkg::SUM_BASE;
        for (int i = 0; i < 512; i++)
            if (i < thv_pkg::CK_FIRST || i > thv_pkg::CK_LAST) sum += hdr_img[i];

        case (style)
            SUMFMT_SIX: begin
                write_octal(148, 6, sum);
                hdr_img[154] = 8'h00;
                hdr_img[155] = 8'h20;
            end
            SUMFMT_SEVEN: begin
                write_octal(148, 7, sum);
                hdr_img[155] = 8'h00;
            end
            SUMFMT_EIGHT: write_octal(148, 8, sum);
            SUMFMT_LEAD_SP: begin
                hdr_img[148] = 8'h20;
                write_octal(149, 6, sum);
                hdr_img[155] = 8'h00;
            end
            default: for (int i = 148; i < 156; i++) hdr_img[i] = 8'h37;
        endcase

        if (damage == DMG_ANY)
            hdr_img[$urandom_range(0, 511)] = 8'($urandom_range(0, 255));

        for (int i = 0; i < keep; i++)
            push_byte(hdr_img[i], (i == keep - 1) ? ((keep < 512) ? 1'b1 : end_flag) : 1'b0);
    endtask

    // Accepted requests on both channels, sampled at the rising edge
    always @(posedge aclk) begin
        byte_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                byte_taken = 1'b1;
                bytes_accepted++;
                predict_header_scan(s_data_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result: is_header %0d sum %0d stored %0d",
                           m_is_header, m_computed_sum, m_stored_sum);
                    error_count++;
                end else begin
                    due_verdict = expected_verdicts.pop_front();
                    if (m_is_header !== due_verdict.is_header) begin
                        $error("is_header expected %0d got %0d",
                               due_verdict.is_header, m_is_header);
                        error_count++;
                    end
                    if (m_header_format !== due_verdict.header_format) begin
                        $error("header_format expected %0d got %0d",
                               due_verdict.header_format, m_header_format);
                        error_count++;
                    end
                    if (m_computed_sum !== due_verdict.computed_sum) begin
                        $error("computed_sum expected %0d got %0d",
                               due_verdict.computed_sum, m_computed_sum);
                        error_count++;
                    end
                    if (m_stored_sum !== due_verdict.stored_sum) begin
                        $error("stored_sum expected %0d got %0d",
                               due_verdict.stored_sum, m_stored_sum);
                        error_count++;
                    end
                end
            end
        end
    end

    // Byte driver: next request only once the current one is taken
    always @(negedge aclk) begin
        byte_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            if (byte_feed.size() != 0 && (quiet_window() || $urandom_range(0, 99) >= 27)) begin
                req = byte_feed.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= req.data;
                s_last_byte <= req.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls plus one long hold-off during the short-block burst
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && bytes_accepted >= burst_from) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_window() || $urandom_range(0, 99) >= 27;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int r;
        sum_style_t style;
        damage_t    damage;
        int         keep;
        clear_scan();

        // short blocks: extremes, control characters, bytes after the name NUL
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        push_byte(8'h7f, 1'b1);
        push_byte(8'h80, 1'b1);
        push_byte(8'h20, 1'b0);
        push_byte(8'h1f, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hfe, 1'b1);

        // full blocks of each format, one closed by last_byte on its final byte
        queue_block(MAGIC_POSIX, SUMFMT_SIX, DMG_NONE, 512, 1'b1);
        queue_block(MAGIC_GNU, SUMFMT_SEVEN, DMG_NONE, 512, 1'b0);
        queue_block(MAGIC_NONE, SUMFMT_EIGHT, DMG_NONE, 512, 1'b0);

        // burst of tiny blocks met by a long result hold-off
        burst_from = bytes_queued;
        for (int i = 0; i < 40; i++)
            queue_block(magic_pick_t'($urandom_range(0, 3)), SUMFMT_SIX, DMG_NONE,
                        $urandom_range(1, 3), 1'b0);

        // stretch without idling within the first two full blocks
        quiet_from = 64;
        quiet_to   = quiet_from + 800;
        while ((bytes_queued < 1700 || blocks_queued < 40) && bytes_queued < 12000) begin
            r = $urandom_range(0, 99);
            style = (r < 40) ? SUMFMT_SIX : (r < 70) ? SUMFMT_SEVEN : (r < 90) ? SUMFMT_EIGHT :
                    (r < 96) ? SUMFMT_LEAD_SP : SUMFMT_SEVENS;
            damage = ($urandom_range(0, 99) < 65) ? DMG_NONE : damage_t'($urandom_range(1, 4));
            if ($urandom_range(0, 5) == 0) keep = 512;
            else if ($urandom_range(0, 9) < 8) keep = $urandom_range(1, 24);
            else keep = $urandom_range(1, 511);
            queue_block(magic_pick_t'($urandom_range(0, 3)), style, damage, keep,
                        1'($urandom_range(0, 1)));
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (byte_feed.size() != 0 || s_valid) @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (error_count == 0 && expected_verdicts.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
hdl/thv_pkg.sv
hdl/thv_scan.sv
hdl/tar_header_validator.sv
sim/tb_top.sv
